// File: src/pip_pkg.sv
// ---------------------------------------------------------------------------
// pip_pkg
// shared types and constants of the point-in-polygon test core
// ---------------------------------------------------------------------------
package pip_pkg;

    localparam int IDX_W = 6;                  // vertex slot field width
    localparam int CFG_W = 7;                  // vertex count register width
    localparam logic [CFG_W-1:0] COUNT_RESET = 7'd3;

    localparam logic OPC_LOAD = 1'b0;          // store one vertex
    localparam logic OPC_TEST = 1'b1;          // test one point

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_DONE
    } t_state;

    // control from the sequencer to the edge unit
    typedef struct packed {
        logic clear;        // start of a query, parity back to even
        logic edge_valid;   // the vertex pair at the inputs is an edge in use
    } t_edge_ctrl;

endpackage

// File: src/pip_cell.sv
// ---------------------------------------------------------------------------
// pip_cell
// one vertex slot of the ring: loads by index, shifts to its neighbor
// ---------------------------------------------------------------------------
module pip_cell #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_wr,
    input  logic signed [COORD_WIDTH-1:0] i_wr_x,
    input  logic signed [COORD_WIDTH-1:0] i_wr_y,
    input  logic                          i_shift,
    input  logic signed [COORD_WIDTH-1:0] i_nbr_x,
    input  logic signed [COORD_WIDTH-1:0] i_nbr_y,
    output logic signed [COORD_WIDTH-1:0] o_x,
    output logic signed [COORD_WIDTH-1:0] o_y
);

    logic signed [COORD_WIDTH-1:0] r_x;
    logic signed [COORD_WIDTH-1:0] r_y;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_x <= i_wr_x;
            r_y <= i_wr_y;
        end else if (i_shift) begin
            r_x <= i_nbr_x;
            r_y <= i_nbr_y;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;

endmodule

// File: src/pip_edge.sv
// ---------------------------------------------------------------------------
// pip_edge
// shared edge unit: straddle test, exact crossing compare, parity
// ---------------------------------------------------------------------------
module pip_edge import pip_pkg::*; #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_edge_ctrl                    i_ctrl,
    input  logic signed [COORD_WIDTH-1:0] i_tx,
    input  logic signed [COORD_WIDTH-1:0] i_ty,
    input  logic signed [COORD_WIDTH-1:0] i_xi,
    input  logic signed [COORD_WIDTH-1:0] i_yi,
    input  logic signed [COORD_WIDTH-1:0] i_xj,
    input  logic signed [COORD_WIDTH-1:0] i_yj,
    output logic                          o_inside
);

    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * DW;

    logic signed [DW-1:0] tx_e, ty_e, xi_e, yi_e, xj_e, yj_e;
    logic                 straddle;

    // stage a: differences
    logic                 r_a_vld;
    logic signed [DW-1:0] r_dlx, r_dy, r_dex, r_dey;
    // stage b: products
    logic                 r_b_vld;
    logic                 r_b_neg;
    logic signed [PW-1:0] r_l, r_r;
    // stage c: parity
    logic                 crossing;
    logic                 r_parity;

    assign tx_e = {i_tx[COORD_WIDTH-1], i_tx};
    assign ty_e = {i_ty[COORD_WIDTH-1], i_ty};
    assign xi_e = {i_xi[COORD_WIDTH-1], i_xi};
    assign yi_e = {i_yi[COORD_WIDTH-1], i_yi};
    assign xj_e = {i_xj[COORD_WIDTH-1], i_xj};
    assign yj_e = {i_yj[COORD_WIDTH-1], i_yj};

    assign straddle = (i_yi > i_ty) != (i_yj > i_ty);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else begin
            r_a_vld <= i_ctrl.edge_valid && straddle;
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dlx   <= tx_e - xi_e;
        r_dy    <= yj_e - yi_e;
        r_dex   <= xj_e - xi_e;
        r_dey   <= ty_e - yi_e;
        r_l     <= r_dlx * r_dy;
        r_r     <= r_dex * r_dey;
        r_b_neg <= r_dy[DW-1];
    end

    // tx left of crossing: dlx*|dy| < dex*dey*sign(dy)
    assign crossing = r_b_neg ? (r_l > r_r) : (r_l < r_r);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parity <= 1'b0;
        end else if (i_ctrl.clear) begin
            r_parity <= 1'b0;
        end else if (r_b_vld && crossing) begin
            r_parity <= !r_parity;
        end
    end

    assign o_inside = r_parity;

endmodule

// File: src/point_in_polygon_test_core.sv
// ---------------------------------------------------------------------------
// point_in_polygon_test_core
// crossing-number point-in-polygon test over a ring of vertex cells
// ---------------------------------------------------------------------------
//
// channel   dir  handshake                       payload
// s_axis    in   i_s_axis_tvalid/o_s_axis_tready  tuser opcode, tdata slot,x,y
// m_axis    out  o_m_axis_tvalid/i_m_axis_tready  tdata inside_res
// cfg       in   i_cfg_valid/o_cfg_ready          data vertex_count
//
// a load request leaves the core idle, ready for the next one. a test request
// holds off the input until it is done: the vertex ring rotates once past the
// shared edge unit (MAX_VERTICES + 1 steps, the one at the vertex count closes
// the polygon), then the edge pipeline drains and the answer is handed over.
// reset sets vertex_count to 3 and leaves the vertex cells unwritten.
// a finished answer waits in the output register; the input side keeps
// taking requests, and a later test holds only if that register is still full.
//
module point_in_polygon_test_core import pip_pkg::*; #(
    parameter int  MAX_VERTICES = 64,
    parameter int  COORD_WIDTH  = 32,
    localparam int S_DATA_W     = ((IDX_W + 2 * COORD_WIDTH + 7) / 8) * 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input requests
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    input  logic [S_DATA_W-1:0] i_s_axis_tdata,   // vertex_index, coord_x, coord_y
    input  logic                i_s_axis_tuser,   // opcode
    // results
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    output logic [7:0]          o_m_axis_tdata,   // inside_res
    // vertex count register
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CFG_W-1:0]    i_cfg_data
);

    localparam int CW = $clog2(MAX_VERTICES + 1);     // step counter, holds 0..MAX
    localparam int NW = (CW > CFG_W) ? CW : CFG_W;
    localparam logic [CW-1:0] LAST_STEP = CW'(MAX_VERTICES);

    // request fields
    logic [IDX_W-1:0]              in_idx;
    logic signed [COORD_WIDTH-1:0] in_x;
    logic signed [COORD_WIDTH-1:0] in_y;

    assign in_idx = i_s_axis_tdata[IDX_W-1:0];
    assign in_x   = i_s_axis_tdata[IDX_W +: COORD_WIDTH];
    assign in_y   = i_s_axis_tdata[IDX_W + COORD_WIDTH +: COORD_WIDTH];

    // control registers
    t_state           r_state, n_state;
    logic [CW-1:0]    r_step;
    logic             r_drain;
    logic [CFG_W-1:0] r_vertex_count;
    logic             r_out_valid;
    logic             r_out_inside;

    // query point, first vertex and previous vertex of the walk
    logic signed [COORD_WIDTH-1:0] r_tx, r_ty;
    logic signed [COORD_WIDTH-1:0] r_first_x, r_first_y;
    logic signed [COORD_WIDTH-1:0] r_prev_x, r_prev_y;

    logic       in_fire;
    logic       load_fire;
    logic       test_fire;
    logic       shift;
    logic       out_load;
    t_edge_ctrl edge_ctrl;

    // vertices in use, clipped to the ring length
    logic [NW-1:0] count_ext;
    logic [CW-1:0] n_used;
    logic          at_n;

    assign count_ext = NW'(r_vertex_count);
    assign n_used    = (count_ext > NW'(MAX_VERTICES)) ? LAST_STEP : count_ext[CW-1:0];
    assign at_n      = (r_step == n_used);

    // ring of vertex cells, cell 0 is the head that feeds the edge unit
    logic signed [COORD_WIDTH-1:0] w_x [MAX_VERTICES];
    logic signed [COORD_WIDTH-1:0] w_y [MAX_VERTICES];

    for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
        logic wr_sel;
        assign wr_sel = load_fire && (32'(in_idx) == k);

        pip_cell #(
            .COORD_WIDTH (COORD_WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_wr    (wr_sel),
            .i_wr_x  (in_x),
            .i_wr_y  (in_y),
            .i_shift (shift),
            .i_nbr_x (w_x[(k + 1) % MAX_VERTICES]),
            .i_nbr_y (w_y[(k + 1) % MAX_VERTICES]),
            .o_x     (w_x[k]),
            .o_y     (w_y[k])
        );
    end

    // sequencer
    always_comb begin
        n_state              = r_state;
        o_s_axis_tready      = 1'b0;
        shift                = 1'b0;
        out_load             = 1'b0;
        edge_ctrl.clear      = 1'b0;
        edge_ctrl.edge_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                edge_ctrl.clear = test_fire;
                if (test_fire) begin
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                shift = (r_step != LAST_STEP);
                // inner edges while the head walks, closing edge at step n
                edge_ctrl.edge_valid = ((r_step != '0) && (r_step < n_used))
                                    || (at_n && (n_used != '0));
                if (r_step == LAST_STEP) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (r_drain) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign in_fire   = i_s_axis_tvalid && o_s_axis_tready;
    assign load_fire = in_fire && (i_s_axis_tuser == OPC_LOAD);
    assign test_fire = in_fire && (i_s_axis_tuser == OPC_TEST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
            r_drain <= 1'b0;
        end else begin
            r_state <= n_state;
            if (test_fire) begin
                r_step <= '0;
            end else if (r_state == ST_WALK && r_step != LAST_STEP) begin
                r_step <= r_step + 1'b1;
            end
            if (r_state == ST_DRAIN) begin
                r_drain <= !r_drain;
            end else begin
                r_drain <= 1'b0;
            end
        end
    end

    // query point and walk registers
    always_ff @(posedge i_clk) begin
        if (test_fire) begin
            r_tx <= in_x;
            r_ty <= in_y;
        end
        if (r_state == ST_WALK && r_step == '0) begin
            r_first_x <= w_x[0];
            r_first_y <= w_y[0];
        end
        if (r_state == ST_WALK && r_step < n_used) begin
            r_prev_x <= w_x[0];
            r_prev_y <= w_y[0];
        end
    end

    // edge (i, j): j is the previous vertex, i the head or, at step n, vertex 0
    logic signed [COORD_WIDTH-1:0] xi, yi;
    logic                          edge_inside;

    assign xi = at_n ? r_first_x : w_x[0];
    assign yi = at_n ? r_first_y : w_y[0];

    pip_edge #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_edge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (edge_ctrl),
        .i_tx     (r_tx),
        .i_ty     (r_ty),
        .i_xi     (xi),
        .i_yi     (yi),
        .i_xj     (r_prev_x),
        .i_yj     (r_prev_y),
        .o_inside (edge_inside)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_inside <= edge_inside;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'b0, r_out_inside};

    // vertex count register, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= COUNT_RESET;
        end else if (i_cfg_valid) begin
            r_vertex_count <= i_cfg_data;
        end
    end

endmodule

// File: sim/point_in_polygon_test_core_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// point_in_polygon_test_core_test
// self-checking bench for the crossing-number point-in-polygon core
// ---------------------------------------------------------------------------
//
// vertex loads and point tests go in on the request stream. A software copy of
// the vertex store and of the even-odd walk predicts each untyped inside bit, and
// answers are matched in order. A short table comes first: a small triangle,
// the coordinate extremes, points on the boundary and a test whose slot field
// must be ignored. Then all slots are filled and a series of vertex counts is
// run with random loads and tests. The counts include 0, 1 and 2, the full 64,
// and values above capacity. Both stream sides pause at random, one phase
// runs with no pauses, and the result side holds off once for a long stretch.
//
module point_in_polygon_test_core_test;
    import pip_pkg::*;

    localparam int MAX_VERTICES = 64;
    localparam int COORD_WIDTH  = 32;
    localparam int S_DATA_W     = ((IDX_W + 2 * COORD_WIDTH + 7) / 8) * 8;

    // length in cycles of one test, walking the ring and draining
    localparam int TEST_CYCLES  = MAX_VERTICES + 5;
    localparam int DRAIN_CYCLES = 2 * TEST_CYCLES;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 400000;

    localparam int PHASE_ITEMS  = 55;
    localparam int SHORT_ITEMS  = 15;     // counts 0 and 1 always answer outside
    localparam int CALM_PHASE   = 7;      // no pauses on either side here
    localparam int RANDOM_COUNT = -1;     // phase count picked at run time
    localparam int PHASE_COUNTS [10] = '{64, 0, 1, 2, 127, 5, 3, RANDOM_COUNT, 100, 64};

    // Q16.16 handy values
    localparam logic signed [31:0] Q_ONE   = 32'sd65536;
    localparam logic signed [31:0] Q_TWO   = 32'sd131072;
    localparam logic signed [31:0] Q_FIVE  = 32'sd327680;
    localparam logic signed [31:0] Q_TEN   = 32'sd655360;
    localparam logic signed [31:0] Q_TWNTY = 32'sd1310720;
    localparam logic signed [31:0] C_MAX   = 32'sh7fff_ffff;
    localparam logic signed [31:0] C_MIN   = 32'sh8000_0000;

    typedef struct packed {
        logic                     opc;
        logic [IDX_W-1:0]         slot;
        logic signed [31:0]       x;
        logic signed [31:0]       y;
        logic                     typed;    // expected answer given in the row
        logic                     answer;
    } t_request_row;

    // reset count is 3, so only slots 0..2 are walked here
    localparam int N_DIRECTED = 21;
    localparam t_request_row DIRECTED [N_DIRECTED] = '{
        // right triangle (0,0) (10,0) (0,10)
        '{OPC_LOAD, 6'd0,  32'sd0,  32'sd0,  1'b0, 1'b0},
        '{OPC_LOAD, 6'd1,  Q_TEN,   32'sd0,  1'b0, 1'b0},
        '{OPC_LOAD, 6'd2,  32'sd0,  Q_TEN,   1'b0, 1'b0},
        '{OPC_TEST, 6'd0,  Q_ONE,   Q_ONE,   1'b1, 1'b1},
        '{OPC_TEST, 6'd0,  Q_TWNTY, Q_TWNTY, 1'b1, 1'b0},
        '{OPC_TEST, 6'd0,  -Q_ONE,  Q_ONE,   1'b1, 1'b0},
        // on the left edge, the bottom edge, the hypotenuse and the corner at the origin
        '{OPC_TEST, 6'd0,  32'sd0,  Q_FIVE,  1'b0, 1'b0},
        '{OPC_TEST, 6'd0,  Q_FIVE,  32'sd0,  1'b0, 1'b0},
        '{OPC_TEST, 6'd0,  Q_FIVE,  Q_FIVE,  1'b0, 1'b0},
        '{OPC_TEST, 6'd0,  32'sd0,  32'sd0,  1'b0, 1'b0},
        // slot field of a test has no meaning
        '{OPC_TEST, 6'd63, Q_TWO,   Q_TWO,   1'b1, 1'b1},
        // highest slot, not walked at count 3
        '{OPC_LOAD, 6'd63, C_MAX,   C_MIN,   1'b0, 1'b0},
        // triangle spanning the whole coordinate range
        '{OPC_LOAD, 6'd0,  C_MIN,   C_MIN,   1'b0, 1'b0},
        '{OPC_LOAD, 6'd1,  C_MAX,   C_MIN,   1'b0, 1'b0},
        '{OPC_LOAD, 6'd2,  32'sd0,  C_MAX,   1'b0, 1'b0},
        '{OPC_TEST, 6'd0,  32'sd0,  32'sd0,  1'b0, 1'b0},
        '{OPC_TEST, 6'd0,  C_MAX,   C_MAX,   1'b0, 1'b0},
        '{OPC_TEST, 6'd0,  C_MIN,   C_MIN,   1'b0, 1'b0},
        '{OPC_TEST, 6'd0,  C_MIN,   C_MAX,   1'b0, 1'b0},
        '{OPC_TEST, 6'd0,  C_MAX,   -Q_ONE,  1'b0, 1'b0},
        // on the bottom edge: only the right edge is crossed
        '{OPC_TEST, 6'd0,  -Q_ONE,  C_MIN,   1'b1, 1'b1}
    };

    logic                i_clk;
    logic                i_rst_n;
    logic                s_valid;
    logic [S_DATA_W-1:0] s_data;
    logic                s_user;
    logic                m_ready;
    logic                cfg_valid;
    logic [CFG_W-1:0]    cfg_data;
    logic                o_s_axis_tready;
    logic                o_m_axis_tvalid;
    logic [7:0]          o_m_axis_tdata;
    logic                o_cfg_ready;

    // predictor state
    logic signed [31:0]  vertex_x [MAX_VERTICES];
    logic signed [31:0]  vertex_y [MAX_VERTICES];
    logic [CFG_W-1:0]    vertex_count;
    logic                inside_expected [$];

    int   mismatch_count = 0;
    bit   calm           = 1'b0;     // no pauses on either side
    bit   hold_request   = 1'b0;     // result side should hold off once

    point_in_polygon_test_core #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_WIDTH  (COORD_WIDTH)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),      // vertex_index, coord_x, coord_y
        .i_s_axis_tuser  (s_user),      // opcode
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata), // inside_res
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // even-odd walk over the vertices in use, exact cross-multiplied compare
    function automatic logic polygon_contains(logic signed [31:0] tx,
                                              logic signed [31:0] ty);
        int                 n;
        int                 j;
        logic               parity;
        logic signed [71:0] dy;
        logic signed [71:0] lx;
        logic signed [71:0] ex;
        logic signed [71:0] ey;
        logic signed [71:0] lhs;
        logic signed [71:0] rhs;
        n      = (vertex_count > MAX_VERTICES) ? MAX_VERTICES : int'(vertex_count);
        parity = 1'b0;
        j      = n - 1;
        for (int i = 0; i < n; i++) begin
            // edge straddles the query y: exactly one end strictly above
            if ((vertex_y[i] > ty) != (vertex_y[j] > ty)) begin
                dy  = vertex_y[j] - vertex_y[i];
                lx  = tx - vertex_x[i];
                ex  = vertex_x[j] - vertex_x[i];
                ey  = ty - vertex_y[i];
                lhs = lx * ((dy < 0) ? -dy : dy);
                rhs = ex * ey;
                if (dy < 0) rhs = -rhs;
                if (lhs < rhs) parity = ~parity;
            end
            j = i;
        end
        return parity;
    endfunction

    // offer one request, hold it until taken, then update the predictor
    task automatic send_request(t_request_row row);
        if (!calm) begin
            while ($urandom_range(99) < 28) begin
                s_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_valid <= 1'b1;
        s_user  <= row.opc;
        s_data  <= {{(S_DATA_W - IDX_W - 64){1'b0}}, row.y, row.x, row.slot};
        do @(posedge i_clk); while (!o_s_axis_tready);
        if (row.opc == OPC_LOAD) begin
            vertex_x[row.slot] = row.x;
            vertex_y[row.slot] = row.y;
        end else begin
            inside_expected.push_back(row.typed ? row.answer
                                                : polygon_contains(row.x, row.y));
        end
    endtask

    // stop offering, let every answer come back, then let the core go quiet
    task automatic settle();
        s_valid <= 1'b0;
        while (inside_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_vertex_count(logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid    <= 1'b0;
        vertex_count = value;
    endtask

    // a small grid most often (many boundary hits and level edges), some moderate
    // spread, some full-range noise
    function automatic logic signed [31:0] pick_coord(int kind);
        if (kind < 45)
            return (int'($urandom_range(8)) - 4) * Q_ONE;
        else if (kind < 85)
            return int'($urandom_range(2097152)) - 1048576;
        else
            return $urandom;
    endfunction

    function automatic t_request_row random_request();
        t_request_row row;
        int           kind;
        kind       = $urandom_range(99);
        row.opc    = ($urandom_range(99) < 35) ? OPC_LOAD : OPC_TEST;
        row.slot   = IDX_W'($urandom_range(MAX_VERTICES - 1));
        row.x      = pick_coord(kind);
        row.y      = pick_coord(kind);
        row.typed  = 1'b0;
        row.answer = 1'b0;
        return row;
    endfunction

    // request side and phase sequencing
    initial begin : stimulus
        t_request_row row;
        int           items;
        int           count_value;
        i_rst_n   <= 1'b0;
        s_valid   <= 1'b0;
        s_user    <= OPC_LOAD;
        s_data    <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= COUNT_RESET;
        vertex_count = COUNT_RESET;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED[k]) send_request(DIRECTED[k]);

        // fill every slot so that no count ever walks an unwritten vertex
        for (int s = 0; s < MAX_VERTICES; s++) begin
            row        = random_request();
            row.opc    = OPC_LOAD;
            row.slot   = IDX_W'(s);
            send_request(row);
        end

        foreach (PHASE_COUNTS[p]) begin
            settle();
            count_value = (PHASE_COUNTS[p] == RANDOM_COUNT) ? $urandom_range(3, MAX_VERTICES)
                                                            : PHASE_COUNTS[p];
            write_vertex_count(CFG_W'(count_value));
            calm  = (p == CALM_PHASE);
            items = (count_value < 2) ? SHORT_ITEMS : PHASE_ITEMS;
            for (int k = 0; k < items; k++) begin
                // long hold on the result side while requests keep coming
                if (p == 0 && k == 10) hold_request = 1'b1;
                send_request(random_request());
            end
            calm = 1'b0;
        end

        settle();
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // result side: random stalls, one long hold, in-order compare
    initial begin : result_sink
        int   hold_left;
        bit   hold_done;
        logic inside_want;
        hold_left = 0;
        hold_done = 1'b0;
        m_ready   <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_axis_tvalid && m_ready) begin
                if (inside_expected.size() == 0) begin
                    $error("inside_res: no answer expected, got %0d", o_m_axis_tdata[0]);
                    mismatch_count++;
                end else begin
                    inside_want = inside_expected.pop_front();
                    if (o_m_axis_tdata[0] !== inside_want) begin
                        $error("inside_res: expected %0d, got %0d",
                               inside_want, o_m_axis_tdata[0]);
                        mismatch_count++;
                    end
                end
            end
            if (hold_request && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (calm) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(99) >= 28);
            end
        end
    end

    // hang guard
    initial begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("end of test: mismatches");
        $finish;
    end

endmodule
